@@ design/ocf_pkg.sv @@
// Shared types, constants and fixed-point helpers for the observer controller.
package ocf_pkg;

  localparam int DataWidth = 16;                 // signal, coefficient and estimate width
  localparam int FracBits  = 12;                 // Q4.12 fraction bits
  localparam int MulWidth  = DataWidth + 2;      // multiplier operand (drive-minus-offset and error need 17 bits)
  localparam int AccWidth  = 40;                 // product-sum accumulator
  localparam int RndWidth  = AccWidth - FracBits;
  localparam int SumWidth  = RndWidth + 1;
  localparam int StepCount = 13;                 // products per closed-loop sample

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [MulWidth-1:0]  mult_t;
  typedef logic signed [AccWidth-1:0]  acc_t;
  typedef logic signed [RndWidth-1:0]  rnd_t;
  typedef logic signed [SumWidth-1:0]  sum_t;

  // configuration register indexes
  localparam logic [2:0] REG_GAINS  = 3'd0;
  localparam logic [2:0] REG_CROW   = 3'd1;
  localparam logic [2:0] REG_AMAT   = 3'd2;
  localparam logic [2:0] REG_BCOL   = 3'd3;
  localparam logic [2:0] REG_LGAIN  = 3'd4;
  localparam logic [2:0] REG_LIMITS = 3'd5;
  localparam logic [2:0] REG_OFFSET = 3'd6;
  localparam logic [2:0] REG_LAW    = 3'd7;

  // request to the serial multiply-accumulate unit
  typedef struct packed {
    logic  start;
    logic  clr;
    logic  neg;
    data_t coef;
    mult_t mult;
  } mac_req_t;

  // round half up, back to Q.FracBits
  function automatic rnd_t round_q(input acc_t acc);
    acc_t t;
    t = acc + (acc_t'(1) <<< (FracBits - 1));
    return rnd_t'(t >>> FracBits);
  endfunction

  // saturate to the signed data range
  function automatic data_t sat_d(input sum_t v);
    sum_t hi;
    sum_t lo;
    hi = sum_t'({1'b0, {(DataWidth-1){1'b1}}});
    lo = -hi - sum_t'(1);
    if (v > hi) return data_t'(hi);
    if (v < lo) return data_t'(lo);
    return data_t'(v);
  endfunction

  // limit to the maximum first, then raise to the minimum
  function automatic data_t clamp_drv(input sum_t v, input data_t lo, input data_t hi);
    sum_t t;
    t = v;
    if (t > sum_t'(hi)) t = sum_t'(hi);
    if (t < sum_t'(lo)) t = sum_t'(lo);
    return data_t'(t);
  endfunction

endpackage

@@ design/ocf_smac.sv @@
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module ocf_smac import ocf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output logic     done,
  output acc_t     acc
);

  localparam int CntWidth = $clog2(MulWidth);

  acc_t                sh_r, sh_nxt;
  mult_t               mb_r, mb_nxt;
  acc_t                acc_r, acc_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic                neg_r, neg_nxt;
  logic                sub;

  // one shift-add step; the top multiplier bit carries negative weight
  always_comb begin
    sh_nxt   = sh_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    sub      = (cnt_r == CntWidth'(MulWidth - 1)) ^ neg_r;
    if (req.start) begin
      sh_nxt  = acc_t'(req.coef);
      mb_nxt  = req.mult;
      neg_nxt = req.neg;
      cnt_nxt = '0;
      run_nxt = 1'b1;
      if (req.clr) acc_nxt = '0;
    end else if (run_r) begin
      if (mb_r[0]) acc_nxt = sub ? acc_r - sh_r : acc_r + sh_r;
      sh_nxt = sh_r <<< 1;
      mb_nxt = mb_r >>> 1;
      cnt_nxt = cnt_r + CntWidth'(1);
      if (cnt_r == CntWidth'(MulWidth - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

@@ design/observer_state_feedback_controller.sv @@
// Top level: configuration, sample sequencer and observer state of the controller.
//
//  channel   dir  handshake                fields
//  in_       in   in_tvalid / in_tready    tdata: reference, measurement; tuser: mode
//  out_      out  out_tvalid / out_tready  tdata: drive
//  cfg_      in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Open-loop samples skip the MAC: the drive is registered, then moved to the output register.
// Closed-loop samples run 13 products through one bit-serial MAC, each as issue,
// 18 multiplier bits, then result.
// Reset (synchronous, rst_n low) clears estimates, registers and handshake state.
// A result waiting on out_tready holds the sequencer; cfg_ready is always high.
module observer_state_feedback_controller import ocf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] reference, [31:16] measurement
  input  logic        in_tuser,    // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] drive
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic [3:0] ACT_NONE  = 4'd0;
  localparam logic [3:0] ACT_DRIVE = 4'd1;
  localparam logic [3:0] ACT_ERR   = 4'd2;
  localparam logic [3:0] ACT_T1    = 4'd3;
  localparam logic [3:0] ACT_T2    = 4'd4;
  localparam logic [3:0] ACT_PX2   = 4'd5;
  localparam logic [3:0] ACT_LX1   = 4'd6;
  localparam logic [3:0] ACT_LX2   = 4'd7;

  localparam logic [3:0] LastStep = 4'(StepCount - 1);

  // configuration registers
  logic [47:0] gains_r;
  logic [31:0] crow_r, bcol_r, lgain_r, limits_r;
  logic [63:0] amat_r;
  data_t       offset_r;
  logic        law_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r  <= '0;
      crow_r   <= '0;
      amat_r   <= '0;
      bcol_r   <= '0;
      lgain_r  <= '0;
      limits_r <= '0;
      offset_r <= '0;
      law_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAINS:  gains_r  <= cfg_data[47:0];
        REG_CROW:   crow_r   <= cfg_data[31:0];
        REG_AMAT:   amat_r   <= cfg_data;
        REG_BCOL:   bcol_r   <= cfg_data[31:0];
        REG_LGAIN:  lgain_r  <= cfg_data[31:0];
        REG_LIMITS: limits_r <= cfg_data[31:0];
        REG_OFFSET: offset_r <= data_t'(cfg_data[15:0]);
        REG_LAW:    law_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  data_t lim_lo, lim_hi;
  assign lim_lo = data_t'(limits_r[15:0]);
  assign lim_hi = data_t'(limits_r[31:16]);

  // sequencer and datapath registers
  logic [1:0] state_r, state_nxt;
  logic [3:0] st_r, st_nxt;
  data_t      ref_r, ref_nxt, meas_r, meas_nxt;
  data_t      x1_r, x1_nxt, x2_r, x2_nxt;
  data_t      t1_r, t1_nxt, t2_r, t2_nxt;
  mult_t      ap_r, ap_nxt, err_r, err_nxt;
  data_t      drive_r, drive_nxt;
  logic       out_vld_r, out_vld_nxt;

  mac_req_t   mreq;
  logic       mac_done;
  acc_t       mac_acc;
  rnd_t       acc_rnd;

  data_t      op_coef;
  mult_t      op_mult;
  logic       op_neg, op_clr;
  logic [3:0] op_act;

  // product schedule: coefficient, multiplier, sign, clear and follow-up action
  always_comb begin
    op_coef = '0;
    op_mult = '0;
    op_neg  = 1'b0;
    op_clr  = 1'b0;
    op_act  = ACT_NONE;
    case ({law_r, st_r})
      5'h00, 5'h10: begin op_coef = data_t'(gains_r[15:0]);  op_mult = mult_t'(ref_r);
                          op_clr = 1'b1; end
      5'h01, 5'h11: begin op_coef = data_t'(gains_r[31:16]); op_mult = mult_t'(x1_r);
                          op_neg = 1'b1; end
      5'h02, 5'h12: begin op_coef = data_t'(gains_r[47:32]); op_mult = mult_t'(x2_r);
                          op_neg = 1'b1; op_act = ACT_DRIVE; end
      // predictor law
      5'h13: begin op_coef = data_t'(crow_r[15:0]);  op_mult = mult_t'(x1_r); op_clr = 1'b1; end
      5'h14: begin op_coef = data_t'(crow_r[31:16]); op_mult = mult_t'(x2_r); op_act = ACT_ERR; end
      5'h15: begin op_coef = data_t'(amat_r[15:0]);  op_mult = mult_t'(x1_r); op_clr = 1'b1; end
      5'h16: begin op_coef = data_t'(amat_r[31:16]); op_mult = mult_t'(x2_r); end
      5'h17: begin op_coef = data_t'(bcol_r[15:0]);  op_mult = ap_r; end
      5'h18: begin op_coef = data_t'(lgain_r[15:0]); op_mult = err_r; op_act = ACT_T1; end
      5'h19: begin op_coef = data_t'(amat_r[47:32]); op_mult = mult_t'(x1_r); op_clr = 1'b1; end
      5'h1a: begin op_coef = data_t'(amat_r[63:48]); op_mult = mult_t'(x2_r); end
      5'h1b: begin op_coef = data_t'(bcol_r[31:16]); op_mult = ap_r; end
      5'h1c: begin op_coef = data_t'(lgain_r[31:16]); op_mult = err_r; op_act = ACT_PX2; end
      // current law
      5'h03: begin op_coef = data_t'(amat_r[15:0]);  op_mult = mult_t'(x1_r); op_clr = 1'b1; end
      5'h04: begin op_coef = data_t'(amat_r[31:16]); op_mult = mult_t'(x2_r); end
      5'h05: begin op_coef = data_t'(bcol_r[15:0]);  op_mult = ap_r; op_act = ACT_T1; end
      5'h06: begin op_coef = data_t'(amat_r[47:32]); op_mult = mult_t'(x1_r); op_clr = 1'b1; end
      5'h07: begin op_coef = data_t'(amat_r[63:48]); op_mult = mult_t'(x2_r); end
      5'h08: begin op_coef = data_t'(bcol_r[31:16]); op_mult = ap_r; op_act = ACT_T2; end
      5'h09: begin op_coef = data_t'(crow_r[15:0]);  op_mult = mult_t'(t1_r); op_clr = 1'b1; end
      5'h0a: begin op_coef = data_t'(crow_r[31:16]); op_mult = mult_t'(t2_r); op_act = ACT_ERR; end
      5'h0b: begin op_coef = data_t'(lgain_r[15:0]); op_mult = err_r; op_clr = 1'b1;
                   op_act = ACT_LX1; end
      5'h0c: begin op_coef = data_t'(lgain_r[31:16]); op_mult = err_r; op_clr = 1'b1;
                   op_act = ACT_LX2; end
      default: ;
    endcase
  end

  assign mreq.start = (state_r == S_ISSUE);
  assign mreq.clr   = op_clr;
  assign mreq.neg   = op_neg;
  assign mreq.coef  = op_coef;
  assign mreq.mult  = op_mult;

  ocf_smac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  assign acc_rnd = round_q(mac_acc);

  // sample sequencing and post-product actions
  always_comb begin
    state_nxt   = state_r;
    st_nxt      = st_r;
    ref_nxt     = ref_r;
    meas_nxt    = meas_r;
    x1_nxt      = x1_r;
    x2_nxt      = x2_r;
    t1_nxt      = t1_r;
    t2_nxt      = t2_r;
    ap_nxt      = ap_r;
    err_nxt     = err_r;
    drive_nxt   = drive_r;
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ref_nxt  = data_t'(in_tdata[15:0]);
          meas_nxt = data_t'(in_tdata[31:16]);
          st_nxt   = '0;
          if (in_tuser) begin
            drive_nxt = clamp_drv(sum_t'(data_t'(in_tdata[15:0])) + sum_t'(offset_r),
                                  lim_lo, lim_hi);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (mac_done) begin
          case (op_act)
            ACT_DRIVE: begin
              drive_nxt = clamp_drv(sum_t'(acc_rnd) + sum_t'(offset_r), lim_lo, lim_hi);
              ap_nxt    = mult_t'(drive_nxt) - mult_t'(offset_r);
            end
            ACT_ERR: err_nxt = mult_t'(meas_r) - mult_t'(sat_d(sum_t'(acc_rnd)));
            ACT_T1:  t1_nxt  = sat_d(sum_t'(acc_rnd));
            ACT_T2:  t2_nxt  = sat_d(sum_t'(acc_rnd));
            ACT_PX2: begin
              x1_nxt = t1_r;
              x2_nxt = sat_d(sum_t'(acc_rnd));
            end
            ACT_LX1: t1_nxt = sat_d(sum_t'(t1_r) + sum_t'(acc_rnd));
            ACT_LX2: begin
              x1_nxt = t1_r;
              x2_nxt = sat_d(sum_t'(t2_r) + sum_t'(acc_rnd));
            end
            default: ;
          endcase
          if (st_r == LastStep) begin
            state_nxt = S_OUT;
          end else begin
            st_nxt    = st_r + 4'd1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ref_r   <= ref_nxt;
    meas_r  <= meas_nxt;
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    ap_r    <= ap_nxt;
    err_r   <= err_nxt;
    drive_r <= drive_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      st_r      <= '0;
      x1_r      <= '0;
      x2_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      st_r      <= st_nxt;
      x1_r      <= x1_nxt;
      x2_r      <= x2_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // output register holds the drive until taken
  logic [15:0] drive_q;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_vld_r || out_tready)) drive_q <= drive_r;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = drive_q;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_WAIT)
    else $error("multiply result outside wait state");

  a_open_loop_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> state_r == S_OUT)
    else $error("open-loop request did not go straight to output");

  a_est_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WAIT) |=> ($stable(x1_r) && $stable(x2_r)))
    else $error("estimates changed outside product completion");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the observer-based state feedback controller.
module testbench;
  import ocf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] reference, [31:16] measurement
  logic        in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] drive
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  typedef struct packed {
    logic        mode;
    logic [15:0] ref_v;
    logic [15:0] meas;
  } sample_t;

  observer_state_feedback_controller dut (.*);

  // controller registers and estimates as the predictor sees them
  logic [47:0] p_gains;
  logic [31:0] p_crow, p_bcol, p_lgain, p_limits;
  logic [63:0] p_amat;
  logic [15:0] p_offset;
  logic        p_law;
  longint      est1, est2;

  sample_t     pending_samples[$];
  logic [15:0] drive_expected[$];
  int          fail_count;
  bit          hold_off;
  int          stall_cycles;

  function automatic longint fld(logic [63:0] w, int i);
    return longint'($signed(w[16*i +: 16]));
  endfunction

  function automatic longint rnd_q(longint acc);
    longint t;
    t = acc + 2048;
    return t >>> 12;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clamp_drive(longint v);
    if (v > fld(p_limits, 1)) v = fld(p_limits, 1);
    if (v < fld(p_limits, 0)) v = fld(p_limits, 0);
    return v;
  endfunction

  // one sample through the control law and the observer update
  function automatic logic [15:0] predict_drive(sample_t s);
    longint r, y, off, x1, x2, ua, drv, ap, e, t1, t2;
    r   = longint'($signed(s.ref_v));
    y   = longint'($signed(s.meas));
    off = longint'($signed(p_offset));
    x1  = est1;
    x2  = est2;
    if (s.mode) begin
      drv = clamp_drive(r + off);
      return drv[15:0];
    end
    ua  = rnd_q(fld(p_gains, 0) * r - fld(p_gains, 1) * x1 - fld(p_gains, 2) * x2);
    drv = clamp_drive(ua + off);
    ap  = drv - off;
    if (p_law) begin
      e = y - sat16(rnd_q(fld(p_crow, 0) * x1 + fld(p_crow, 1) * x2));
      est1 = sat16(rnd_q(fld(p_amat, 0) * x1 + fld(p_amat, 1) * x2
                         + fld(p_bcol, 0) * ap + fld(p_lgain, 0) * e));
      est2 = sat16(rnd_q(fld(p_amat, 2) * x1 + fld(p_amat, 3) * x2
                         + fld(p_bcol, 1) * ap + fld(p_lgain, 1) * e));
    end else begin
      t1 = sat16(rnd_q(fld(p_amat, 0) * x1 + fld(p_amat, 1) * x2 + fld(p_bcol, 0) * ap));
      t2 = sat16(rnd_q(fld(p_amat, 2) * x1 + fld(p_amat, 3) * x2 + fld(p_bcol, 1) * ap));
      e  = y - sat16(rnd_q(fld(p_crow, 0) * t1 + fld(p_crow, 1) * t2));
      est1 = sat16(t1 + rnd_q(fld(p_lgain, 0) * e));
      est2 = sat16(t2 + rnd_q(fld(p_lgain, 1) * e));
    end
    return drv[15:0];
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // driver: bursts with random gaps
  int gap_left;
  int burst_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_expected.push_back(predict_drive(pending_samples.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // hold the current request
      end else if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_samples.size() > 0) begin
        sample_t nx;
        nx = pending_samples[0];
        in_tvalid <= 1'b1;
        in_tdata  <= {nx.meas, nx.ref_v};
        in_tuser  <= nx.mode;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (hold_off && stall_cycles < 3000) begin
        stall_cycles <= stall_cycles + 1;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_expected.size() == 0) begin
        $error("drive: unexpected result %0d", $signed(out_tdata));
        fail_count++;
      end else begin
        logic [15:0] want;
        want = drive_expected.pop_front();
        if (out_tdata !== want) begin
          $error("drive: expected %0d, actual %0d", $signed(want), $signed(out_tdata));
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GAINS:  p_gains  = val[47:0];
      REG_CROW:   p_crow   = val[31:0];
      REG_AMAT:   p_amat   = val;
      REG_BCOL:   p_bcol   = val[31:0];
      REG_LGAIN:  p_lgain  = val[31:0];
      REG_LIMITS: p_limits = val[31:0];
      REG_OFFSET: p_offset = val[15:0];
      REG_LAW:    p_law    = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_tvalid || drive_expected.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [15:0] small_coef();
    return 16'($signed($urandom_range(0, 4096)) - 2048);
  endfunction

  // stable-ish random settings, with a chance of full-range words
  task automatic random_settings(bit wild);
    if (wild) begin
      write_reg(REG_GAINS, {$urandom, $urandom});
      write_reg(REG_CROW, {32'h0, $urandom});
      write_reg(REG_AMAT, {$urandom, $urandom});
      write_reg(REG_BCOL, {32'h0, $urandom});
      write_reg(REG_LGAIN, {32'h0, $urandom});
      write_reg(REG_LIMITS, {32'h0, $urandom});
      write_reg(REG_OFFSET, {$urandom, $urandom});
    end else begin
      write_reg(REG_GAINS, {16'h0, small_coef(), small_coef(), 16'($urandom_range(0, 8192))});
      write_reg(REG_CROW, {32'h0, small_coef(), 16'h1000});
      write_reg(REG_AMAT, {16'h0e00 + small_coef() / 4, small_coef(),
                           small_coef(), 16'h0e00 + small_coef() / 4});
      write_reg(REG_BCOL, {32'h0, small_coef(), small_coef()});
      write_reg(REG_LGAIN, {32'h0, small_coef(), small_coef()});
      write_reg(REG_LIMITS, {32'h0, 16'h7000 - 16'($urandom_range(0, 8192)),
                             16'h9000 + 16'($urandom_range(0, 8192))});
      write_reg(REG_OFFSET, {48'h0, 16'($urandom_range(0, 4096))});
    end
    write_reg(REG_LAW, {$urandom, $urandom});
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    s.mode  = ($urandom_range(0, 4) == 0);
    s.ref_v = $urandom;
    s.meas  = $urandom;
    if ($urandom_range(0, 1)) begin
      s.ref_v = 16'($signed($urandom_range(0, 8192)) - 4096);
      s.meas  = 16'($signed($urandom_range(0, 8192)) - 4096);
    end
    return s;
  endfunction

  // stimulus
  initial begin
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    p_gains = '0; p_crow = '0; p_amat = '0; p_bcol = '0; p_lgain = '0;
    p_limits = '0; p_offset = '0; p_law = 1'b0; est1 = 0; est2 = 0;
    fail_count = 0; hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero registers, then wide limits with extremes
    pending_samples.push_back('{1'b1, 16'h7fff, 16'h8000});
    pending_samples.push_back('{1'b0, 16'h8000, 16'h7fff});
    wait_drained();
    write_reg(REG_LIMITS, 64'h7fff_8000);
    write_reg(REG_OFFSET, 64'h0800);
    write_reg(REG_GAINS, 64'h0000_7fff_8000_7fff);
    write_reg(REG_CROW, 64'h8000_7fff);
    write_reg(REG_AMAT, 64'h7fff_8000_8000_7fff);
    write_reg(REG_BCOL, 64'h7fff_8000);
    write_reg(REG_LGAIN, 64'h8000_7fff);
    write_reg(REG_LAW, 64'h3);
    for (int m = 0; m < 2; m++) begin
      pending_samples.push_back('{m[0], 16'h7fff, 16'h7fff});
      pending_samples.push_back('{m[0], 16'h8000, 16'h8000});
      pending_samples.push_back('{m[0], 16'h0000, 16'hffff});
      pending_samples.push_back('{m[0], 16'hffff, 16'h0000});
    end
    wait_drained();
    write_reg(REG_LAW, 64'h0);
    for (int i = 0; i < 4; i++) pending_samples.push_back(rand_sample());
    wait_drained();
    // minimum above maximum
    write_reg(REG_LIMITS, 64'h8000_1000);
    write_reg(REG_OFFSET, 64'h8000);
    pending_samples.push_back('{1'b1, 16'h7fff, 16'h0});
    pending_samples.push_back('{1'b0, 16'h1234, 16'h4321});
    wait_drained();

    // random phases
    for (int ph = 0; ph < 16; ph++) begin
      random_settings(ph % 5 == 4);
      for (int i = 0; i < 64; i++) pending_samples.push_back(rand_sample());
      if (ph == 3) begin
        hold_off = 1'b1;
        while (pending_samples.size() > 58) @(posedge clk);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
